// ===== sv/bec_pkg.sv =====
// Shared types and byte codes for the backslash escape codec.
// No dependencies; imported by every module of the codec.
`default_nettype none

package bec_pkg;

	// Special byte codes
	localparam logic [7:0] CODE_BSL  = 8'h5C;
	localparam logic [7:0] CODE_NUL  = 8'h00;
	localparam logic [7:0] CODE_CR   = 8'h0D;
	localparam logic [7:0] CODE_LF   = 8'h0A;
	localparam logic [7:0] CODE_ZERO = 8'h30;
	localparam logic [7:0] CODE_R    = 8'h72;
	localparam logic [7:0] CODE_N    = 8'h6E;

	// Direction register values
	localparam logic DIR_ESCAPE   = 1'b0;
	localparam logic DIR_UNESCAPE = 1'b1;

	// Input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// Command passed from the classifier to the emitter
	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       two;
		logic       last;
	} cmd_t;

	// Classifier status seen by the top level
	typedef struct packed {
		logic direction;
		logic pending;
	} front_status_t;

endpackage

`default_nettype wire

// ===== sv/bec_front.sv =====
// Classifier: accepts input items, tracks the pending escape and builds commands.
// Depends on bec_pkg.
`default_nettype none

module bec_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire bec_pkg::in_item_t      in_data,
	input  wire logic                   queue_full,
	output logic                        push,
	output bec_pkg::cmd_t               push_cmd,
	output bec_pkg::front_status_t      status
);
	import bec_pkg::*;

	logic direction_q;
	logic pending_q;
	logic pending_d;
	logic accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Classify the accepted item
	always_comb begin
		pending_d            = pending_q;
		push                 = 1'b0;
		push_cmd.first_byte  = in_data.data_byte;
		push_cmd.second_byte = in_data.data_byte;
		push_cmd.two         = 1'b0;
		push_cmd.last        = in_data.end_of_string;
		if (accept) begin
			if (direction_q == DIR_ESCAPE) begin
				pending_d = 1'b0;
				push      = 1'b1;
				case (in_data.data_byte)
					CODE_BSL: begin
						push_cmd.first_byte  = CODE_BSL;
						push_cmd.second_byte = CODE_BSL;
						push_cmd.two         = 1'b1;
					end
					CODE_NUL: begin
						push_cmd.first_byte  = CODE_BSL;
						push_cmd.second_byte = CODE_ZERO;
						push_cmd.two         = 1'b1;
					end
					CODE_CR: begin
						push_cmd.first_byte  = CODE_BSL;
						push_cmd.second_byte = CODE_R;
						push_cmd.two         = 1'b1;
					end
					CODE_LF: begin
						push_cmd.first_byte  = CODE_BSL;
						push_cmd.second_byte = CODE_N;
						push_cmd.two         = 1'b1;
					end
					default: begin
						push_cmd.two = 1'b0;
					end
				endcase
			end else if (pending_q) begin
				pending_d = 1'b0;
				push      = 1'b1;
				case (in_data.data_byte)
					CODE_BSL:  push_cmd.first_byte = CODE_BSL;
					CODE_ZERO: push_cmd.first_byte = CODE_NUL;
					CODE_R:    push_cmd.first_byte = CODE_CR;
					CODE_N:    push_cmd.first_byte = CODE_LF;
					default: begin
						// unknown escape: backslash, then the byte itself
						push_cmd.first_byte = CODE_BSL;
						push_cmd.two        = 1'b1;
					end
				endcase
			end else if (in_data.data_byte == CODE_BSL && !in_data.end_of_string) begin
				// hold the backslash until its second byte arrives
				pending_d = 1'b1;
			end else begin
				push = 1'b1;
			end
		end
	end

	// Hold direction and pending flag; a direction write clears the flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ESCAPE;
			pending_q   <= 1'b0;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
			pending_q   <= 1'b0;
		end else begin
			pending_q <= pending_d;
		end
	end

	assign status.direction = direction_q;
	assign status.pending   = pending_q;

endmodule

`default_nettype wire

// ===== sv/bec_queue.sv =====
// Short command queue between classifier and emitter.
// Depends on bec_pkg for the command type.
`default_nettype none

module bec_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire bec_pkg::cmd_t                  push_cmd,
	input  wire logic                           pop,
	output logic                                not_empty,
	output logic                                full,
	output bec_pkg::cmd_t                       head_cmd,
	output logic [$clog2(DEPTH+1)-1:0]          count
);
	import bec_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_cmd  = entry_q[rd_ptr_q];
	assign count     = count_q;

	// Write the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/bec_back.sv =====
// Emitter: takes commands from the queue and sends one or two result items.
// Depends on bec_pkg.
`default_nettype none

module bec_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               queue_valid,
	input  wire bec_pkg::cmd_t      queue_cmd,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bec_pkg::out_item_t      out_data
);
	import bec_pkg::*;

	cmd_t cmd_q;
	logic busy_q;
	logic phase_q;
	logic finishing;

	assign finishing = phase_q || !cmd_q.two;
	assign pop       = queue_valid && (!busy_q || (out_ready && finishing));

	// Advance through the bytes of the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (pop) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			if (finishing) begin
				busy_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	// Load the next command
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= queue_cmd;
		end
	end

	// Drive the result item
	assign out_valid         = busy_q;
	assign out_data.out_byte = phase_q ? cmd_q.second_byte : cmd_q.first_byte;
	assign out_data.out_last = cmd_q.last && finishing;

endmodule

`default_nettype wire

// ===== sv/backslash_escape_codec.sv =====
// Backslash escape codec: one input byte in, zero to two output bytes out.
// Throughput is one item per cycle while out_ready is high and each item gives
// at most one result; an item that gives two results holds the output register
// for both, and items behind it wait in a QUEUE_DEPTH-entry command queue, so
// input stalls only once that queue fills. The first result of an item passes
// through the command queue and then the output register.
// Writing cfg_wdata sets the direction (0 escape,
// 1 unescape) and drops any pending backslash; write only while idle.
// Depends on bec_pkg, bec_front, bec_queue, bec_back.
`default_nettype none

module backslash_escape_codec #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire bec_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output bec_pkg::out_item_t        out_data
);
	import bec_pkg::*;

	logic                             push;
	cmd_t                             push_cmd;
	logic                             pop;
	logic                             queue_valid;
	logic                             queue_full;
	cmd_t                             head_cmd;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count;
	front_status_t                    front_status;

	// Classify items
	bec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.status     (front_status)
	);

	// Buffer commands
	bec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.not_empty (queue_valid),
		.full      (queue_full),
		.head_cmd  (head_cmd),
		.count     (queue_count)
	);

	// Emit result items
	bec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_valid (queue_valid),
		.queue_cmd   (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

`ifndef SYNTHESIS
	// A direction write leaves no backslash pending
	a_cfg_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !front_status.pending)
		else $error("pending escape survived a direction write");

	// Queue occupancy never exceeds its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		queue_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("command queue overflow");

	// Every item accepted in escape mode produces a command
	a_escape_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && front_status.direction == DIR_ESCAPE) |-> push)
		else $error("escape-mode item dropped");

	// Escape mode never holds a pending backslash
	a_escape_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(front_status.direction == DIR_ESCAPE && !cfg_we) |=> !front_status.pending)
		else $error("pending escape in escape mode");
`endif

endmodule

`default_nettype wire
